### hw/rtl/utfd_pkg.sv
package utfd_pkg;

   localparam int unsigned UNIT_W   = 16;
   localparam int unsigned CP_W     = 21;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned PAYLD_W  = 10;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 21;

   localparam logic [KIND_W-1:0] KIND_UNIT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   localparam logic [STATUS_W-1:0] ST_EMIT    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_WAIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_CHAR   = 1'd1;

   localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [UNIT_W-1:0] code_unit;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CP_W-1:0]     code_point;
      logic                is_break;
   } rsp_type;

endpackage

### hw/rtl/utfd_core.sv
module utfd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  utfd_pkg::req_type           req,
   input  logic                        break_enable,
   input  logic [utfd_pkg::CP_W-1:0]   break_char,
   output utfd_pkg::rsp_type           rsp
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PENDING,
      PH_ERROR
   } phase_type;

   phase_type                          phase_ff;
   phase_type                          phase_in;
   logic [utfd_pkg::PAYLD_W-1:0]       high_bits_ff;
   logic [utfd_pkg::PAYLD_W-1:0]       high_bits_in;
   logic [utfd_pkg::STATUS_W-1:0]      status;
   logic [utfd_pkg::CP_W-1:0]          code_point;
   logic                               is_surrogate;
   logic                               is_low;
   logic [utfd_pkg::CP_W-1:0]          pair_cp;

   assign is_surrogate = (req.code_unit[15:11] == 5'b11011);
   assign is_low       = is_surrogate && req.code_unit[10];
   assign pair_cp      = {1'b0, high_bits_ff, req.code_unit[9:0]} + utfd_pkg::SUPP_BASE;

   always_comb begin
      phase_in     = phase_ff;
      high_bits_in = high_bits_ff;
      status       = utfd_pkg::ST_OK;
      code_point   = '0;
      case (req.kind)
         utfd_pkg::KIND_RESTART: begin
            phase_in     = PH_IDLE;
            high_bits_in = '0;
         end
         utfd_pkg::KIND_END: begin
            status = (phase_ff == PH_IDLE) ? utfd_pkg::ST_OK : utfd_pkg::ST_ILLEGAL;
         end
         utfd_pkg::KIND_UNIT: begin
            case (phase_ff)
               PH_IDLE: begin
                  if (is_low) begin
                     phase_in = PH_ERROR;
                     status   = utfd_pkg::ST_ILLEGAL;
                  end else if (is_surrogate) begin
                     phase_in     = PH_PENDING;
                     high_bits_in = req.code_unit[9:0];
                     status       = utfd_pkg::ST_WAIT;
                  end else begin
                     status     = utfd_pkg::ST_EMIT;
                     code_point = {5'd0, req.code_unit};
                  end
               end
               PH_PENDING: begin
                  if (is_low) begin
                     phase_in   = PH_IDLE;
                     status     = utfd_pkg::ST_EMIT;
                     code_point = pair_cp;
                  end else begin
                     phase_in = PH_ERROR;
                     status   = utfd_pkg::ST_ILLEGAL;
                  end
               end
               default: begin
                  status = utfd_pkg::ST_ILLEGAL;
               end
            endcase
         end
         default: begin
            status = utfd_pkg::ST_OK;
         end
      endcase
   end

   assign rsp.status     = status;
   assign rsp.code_point = code_point;
   assign rsp.is_break   = (status == utfd_pkg::ST_EMIT) && break_enable
                           && (code_point == break_char);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         high_bits_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         high_bits_ff <= high_bits_in;
      end
   end

endmodule

### hw/rtl/utf16_to_code_point_decoder.sv
// UTF-16 code unit to Unicode code point decoder.
// Request channel (req_valid, req_stall, req_kind, req_code_unit): one word per
// code unit, end-of-text check or restart. Response channel (rsp_valid,
// rsp_stall, rsp_status, rsp_code_point, rsp_is_break): exactly one word for
// every request word, in order.
// A request word is held in an input register; when the output register is
// free, the decode logic and the surrogate state turn it into a response word
// in the output register. One word is taken every cycle while the receiver
// does not stall.
// When rsp_stall is high the output register holds its word; the input
// register still takes one more word, after which req_stall rises until the
// output register frees up.
// The configuration port (csr_wr_en, csr_index, csr_data) sets break_enable at
// index 0 and break_char at index 1; the user must write it only while the
// block is idle, which the block does not enforce. Reset clears both valid
// flags and break settings, empties the pipeline, leaves no surrogate pending.
module utf16_to_code_point_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [utfd_pkg::KIND_W-1:0]         req_kind,
   input  logic [utfd_pkg::UNIT_W-1:0]         req_code_unit,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [utfd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [utfd_pkg::CP_W-1:0]           rsp_code_point,
   output logic                                rsp_is_break,
   input  logic                                csr_wr_en,
   input  logic [utfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [utfd_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic                           stg_valid_ff;
   utfd_pkg::req_type              stg_req_ff;
   logic                           rsp_valid_ff;
   utfd_pkg::rsp_type              rsp_ff;
   utfd_pkg::rsp_type              rsp_in;
   logic                           break_enable_ff;
   logic [utfd_pkg::CP_W-1:0]      break_char_ff;
   logic                           out_free;
   logic                           advance;
   logic                           accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = stg_valid_ff && out_free;
   assign req_stall = stg_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   utfd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req          (stg_req_ff),
      .break_enable (break_enable_ff),
      .break_char   (break_char_ff),
      .rsp          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (accept) begin
         stg_valid_ff <= 1'b1;
      end else if (advance) begin
         stg_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_req_ff.kind      <= req_kind;
         stg_req_ff.code_unit <= req_code_unit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         break_enable_ff <= 1'b0;
         break_char_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            utfd_pkg::CSR_BREAK_ENABLE: break_enable_ff <= csr_data[0];
            utfd_pkg::CSR_BREAK_CHAR:   break_char_ff   <= csr_data[utfd_pkg::CP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_code_point = rsp_ff.code_point;
   assign rsp_is_break   = rsp_ff.is_break;

`ifndef ASSERT_OFF
   a_emit_not_surrogate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == utfd_pkg::ST_EMIT
      |-> rsp_ff.code_point[20:11] != 10'h01B)
      else $error("emitted code point lies in the surrogate range");

   a_no_emit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != utfd_pkg::ST_EMIT
      |-> rsp_ff.code_point == '0 && !rsp_ff.is_break)
      else $error("non-emit word carries a code point or break flag");

   a_break_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_break |-> break_enable_ff
      && rsp_ff.code_point == break_char_ff)
      else $error("break flag set without a matching enabled break character");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !advance |=> stg_valid_ff && $stable(stg_req_ff))
      else $error("input register lost a word while the output was full");
`endif

endmodule
